[design/newton_divided_difference_interp_top_defines.svh]
// Assertion macros for the Newton interpolation block
`ifndef NEWTON_DIVIDED_DIFFERENCE_INTERP_TOP_DEFINES_SVH
`define NEWTON_DIVIDED_DIFFERENCE_INTERP_TOP_DEFINES_SVH
`ifndef SYNTH
`define NDD_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define NDD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define NDD_ASSERT_IMPL(label, clk, rst, ante, cons)
`define NDD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[design/ndd_pkg.sv]
// Shared types and constants for the Newton interpolation block
package ndd_pkg;
   localparam int NODES = 4;
   localparam int FRAC_BITS = 16;
   localparam int IDX_W = $clog2(NODES);
   localparam int CNT_W = $clog2(NODES + 1);
   localparam int DIV_STEPS = 33 + FRAC_BITS;

   typedef struct packed {
      logic signed [31:0] node_x;
      logic signed [31:0] node_y;
      logic signed [31:0] eval_point;
      logic last_node;
   } req_word_type;

   typedef struct packed {
      logic signed [31:0] interp_value;
      logic divide_fault;
      logic saturated;
   } rsp_word_type;

   typedef enum logic [3:0] {
      ST_LOAD, ST_DD_RD, ST_DD_GO, ST_DD_DIV, ST_DD_WB, ST_HO_RD, ST_HO_SUB, ST_HO_MUL,
      ST_HO_WB, ST_OUT
   } state_type;

   typedef struct packed {
      logic load;
      logic [IDX_W-1:0] load_idx;
      logic dd_rd;
      logic div_start;
      logic dd_wb;
      logic ho_init;
      logic ho_rd;
      logic ho_mul;
      logic ho_wb;
      logic [IDX_W-1:0] idx_i;
      logic [IDX_W-1:0] idx_j;
      logic clear_flags;
   } cmd_type;

   typedef struct packed {
      logic div_done;
   } sts_type;
endpackage

[design/newton_divided_difference_interp_top.sv]
// Newton divided-difference interpolator: one result word per closed node set.
// Each node word is stored as it is accepted; the closing word starts the coefficient build, where each of
// the n(n-1)/2 divided differences passes through operand read, divider start, the shared
// bit-serial divider and write-back; then the top coefficient is fetched and n-1 Horner
// steps follow, each a read of d, a multiply and a write-back, after which the result word
// is shown. The input is closed while the result word waits.
module newton_divided_difference_interp_top (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  ndd_pkg::req_word_type req_word,
   output logic rsp_valid,
   input  logic rsp_ready,
   output ndd_pkg::rsp_word_type rsp_word
);
`include "newton_divided_difference_interp_top_defines.svh"
   ndd_pkg::cmd_type cmd;
   ndd_pkg::sts_type sts;

   ndd_controller u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .req_last(req_word.last_node), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .sts(sts), .cmd(cmd)
   );

   ndd_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .req_word(req_word),
      .sts(sts), .result(rsp_word)
   );

   `NDD_ASSERT_IMPL(a_no_overlap, clock, reset, rsp_valid, !req_ready)
   `NDD_ASSERT_IMPL(a_load_only_ready, clock, reset, cmd.load, req_ready && req_valid)
   `NDD_ASSERT_NEXT(a_clear_after_out, clock, reset, rsp_valid && rsp_ready, !rsp_valid)
endmodule

[design/ndd_divider.sv]
// Iterative restoring divider for divided differences, one quotient bit per cycle
module ndd_divider (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [32+ndd_pkg::FRAC_BITS:0] num_mag,
   input  logic [32:0] den_mag,
   output logic done,
   output logic [32+ndd_pkg::FRAC_BITS:0] quot
);
   localparam int QW = 33 + ndd_pkg::FRAC_BITS;
   logic [QW-1:0] q_ff, q_in;
   logic [33:0] r_ff, r_in;
   logic [32:0] d_ff, d_in;
   logic [6:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic [33:0] trial;

   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      d_in = d_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      trial = {r_ff[32:0], q_ff[QW-1]} - {1'b0, d_ff};
      if (start) begin
         q_in = num_mag;
         r_in = '0;
         d_in = den_mag;
         cnt_in = 7'(QW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[33]) begin
            r_in = trial;
            q_in = {q_ff[QW-2:0], 1'b1};
         end else begin
            r_in = {r_ff[32:0], q_ff[QW-1]};
            q_in = {q_ff[QW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
      cnt_ff <= cnt_in;
      if (reset) busy_ff <= 1'b0;
      else busy_ff <= busy_in;
   end

   assign done = busy_ff && (cnt_ff == 7'd1);
   assign quot = q_in;
endmodule

[design/ndd_datapath.sv]
// Node store, difference, division, Horner arithmetic and fault flags
module ndd_datapath (
   input  logic clock,
   input  logic reset,
   input  ndd_pkg::cmd_type cmd,
   input  ndd_pkg::req_word_type req_word,
   output ndd_pkg::sts_type sts,
   output ndd_pkg::rsp_word_type result
);
   localparam int FB = ndd_pkg::FRAC_BITS;
   localparam int QW = 33 + FB;
   logic signed [31:0] xs_ff [ndd_pkg::NODES];
   logic signed [31:0] cs_ff [ndd_pkg::NODES];
   logic signed [31:0] t_ff, v_ff;
   logic signed [32:0] num_ff, den_ff, d_ff;
   logic [65:0] prod_ff;
   logic neg_ff, div_ff, sat_ff;
   logic [QW-1:0] quot;
   logic div_done;
   logic [QW-1:0] num_mag;
   logic [32:0] den_mag, dmag, vmag;
   logic [65:0] pshift;
   logic signed [34:0] sum;
   logic signed [31:0] qval, hval;
   logic qsat, hsat;

   assign num_mag = {(FB)'(0), (num_ff[32] ? 33'(-num_ff) : 33'(num_ff))} << FB;
   assign den_mag = den_ff[32] ? 33'(-den_ff) : 33'(den_ff);
   assign dmag = d_ff[32] ? 33'(-d_ff) : 33'(d_ff);
   assign vmag = v_ff[31] ? 33'(-{v_ff[31], v_ff}) : 33'({v_ff[31], v_ff});

   ndd_divider u_div (
      .clock(clock), .reset(reset), .start(cmd.div_start),
      .num_mag(num_mag), .den_mag(den_mag), .done(div_done), .quot(quot)
   );
   assign sts.div_done = div_done;

   always_comb begin
      qsat = 1'b0;
      if (!neg_ff) begin
         if (quot > QW'(32'h7fffffff)) begin
            qval = 32'h7fffffff; qsat = 1'b1;
         end else qval = quot[31:0];
      end else begin
         if (quot > QW'(33'h080000000)) begin
            qval = 32'h80000000; qsat = 1'b1;
         end else qval = 32'(-quot[31:0]);
      end
      pshift = prod_ff >> FB;
      sum = neg_ff ? 35'(cs_ff[cmd.idx_i]) - 35'(pshift[34:0])
                   : 35'(cs_ff[cmd.idx_i]) + 35'(pshift[34:0]);
      hsat = 1'b0;
      if (pshift[65:33] != '0) begin
         hsat = 1'b1;
         hval = neg_ff ? 32'h80000000 : 32'h7fffffff;
      end else if (sum > 35'sh07fffffff) begin
         hsat = 1'b1; hval = 32'h7fffffff;
      end else if (sum < -35'sh080000000) begin
         hsat = 1'b1; hval = 32'h80000000;
      end else hval = sum[31:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         xs_ff[cmd.load_idx] <= req_word.node_x;
         cs_ff[cmd.load_idx] <= req_word.node_y;
         t_ff <= req_word.eval_point;
      end
      if (cmd.dd_rd) begin
         num_ff <= 33'(cs_ff[cmd.idx_i]) - 33'(cs_ff[cmd.idx_i - 1'b1]);
         den_ff <= 33'(xs_ff[cmd.idx_i]) - 33'(xs_ff[cmd.idx_i - cmd.idx_j]);
      end
      if (cmd.div_start) neg_ff <= num_ff[32] ^ den_ff[32];
      if (cmd.dd_wb) cs_ff[cmd.idx_i] <= (den_ff == '0) ? '0 : qval;
      if (cmd.ho_init) v_ff <= cs_ff[cmd.idx_i];
      if (cmd.ho_rd) d_ff <= 33'(t_ff) - 33'(xs_ff[cmd.idx_i]);
      if (cmd.ho_mul) begin
         prod_ff <= dmag * vmag;
         neg_ff <= d_ff[32] ^ v_ff[31];
      end
      if (cmd.ho_wb) v_ff <= hval;
      if (reset || cmd.clear_flags) begin
         div_ff <= 1'b0;
         sat_ff <= 1'b0;
      end else begin
         if (cmd.dd_wb && den_ff == '0) div_ff <= 1'b1;
         if (cmd.dd_wb && den_ff != '0 && qsat) sat_ff <= 1'b1;
         if (cmd.ho_wb && hsat) sat_ff <= 1'b1;
      end
   end

   assign result.interp_value = v_ff;
   assign result.divide_fault = div_ff;
   assign result.saturated = sat_ff;
endmodule

[design/ndd_controller.sv]
// Sequencer for node loading, divided differences and Horner steps
module ndd_controller (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic req_last,
   output logic rsp_valid,
   input  logic rsp_ready,
   input  ndd_pkg::sts_type sts,
   output ndd_pkg::cmd_type cmd
);
   localparam int IW = ndd_pkg::IDX_W;
   localparam int CW = ndd_pkg::CNT_W;
   ndd_pkg::state_type state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in, n_ff, n_in;
   logic [CW-1:0] i_ff, i_in, j_ff, j_in;
   logic accept, closes;

   assign accept = req_valid && req_ready;
   assign closes = req_last || (cnt_ff == CW'(ndd_pkg::NODES - 1));

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      n_in = n_ff;
      i_in = i_ff;
      j_in = j_ff;
      case (state_ff)
         ndd_pkg::ST_LOAD: begin
            if (accept) begin
               if (closes) begin
                  n_in = cnt_ff + 1'b1;
                  cnt_in = '0;
                  j_in = CW'(1);
                  i_in = cnt_ff;
                  state_in = (cnt_ff == '0) ? ndd_pkg::ST_HO_RD : ndd_pkg::ST_DD_RD;
               end else cnt_in = cnt_ff + 1'b1;
            end
         end
         ndd_pkg::ST_DD_RD: state_in = ndd_pkg::ST_DD_GO;
         ndd_pkg::ST_DD_GO: state_in = ndd_pkg::ST_DD_DIV;
         ndd_pkg::ST_DD_DIV: if (sts.div_done) state_in = ndd_pkg::ST_DD_WB;
         ndd_pkg::ST_DD_WB: begin
            if (i_ff > j_ff) begin
               i_in = i_ff - 1'b1;
               state_in = ndd_pkg::ST_DD_RD;
            end else if (j_ff + 1'b1 < n_ff) begin
               j_in = j_ff + 1'b1;
               i_in = n_ff - 1'b1;
               state_in = ndd_pkg::ST_DD_RD;
            end else begin
               i_in = n_ff - 1'b1;
               state_in = ndd_pkg::ST_HO_RD;
            end
         end
         ndd_pkg::ST_HO_RD: begin
            if (i_ff == '0) state_in = ndd_pkg::ST_OUT;
            else state_in = ndd_pkg::ST_HO_SUB;
         end
         ndd_pkg::ST_HO_SUB: state_in = ndd_pkg::ST_HO_MUL;
         ndd_pkg::ST_HO_MUL: state_in = ndd_pkg::ST_HO_WB;
         ndd_pkg::ST_HO_WB: begin
            i_in = i_ff - 1'b1;
            state_in = (i_ff == CW'(1)) ? ndd_pkg::ST_OUT : ndd_pkg::ST_HO_SUB;
         end
         ndd_pkg::ST_OUT: if (rsp_ready) state_in = ndd_pkg::ST_LOAD;
         default: state_in = ndd_pkg::ST_LOAD;
      endcase
   end

   // HO_RD loads v from the top coefficient; each Horner step reads d, multiplies, writes v
   always_comb begin
      cmd = '0;
      cmd.load_idx = cnt_ff[IW-1:0];
      cmd.idx_i = i_ff[IW-1:0];
      cmd.idx_j = j_ff[IW-1:0];
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ndd_pkg::ST_LOAD: begin
            req_ready = 1'b1;
            cmd.load = accept;
         end
         ndd_pkg::ST_DD_RD: cmd.dd_rd = 1'b1;
         ndd_pkg::ST_DD_GO: cmd.div_start = 1'b1;
         ndd_pkg::ST_DD_WB: cmd.dd_wb = 1'b1;
         ndd_pkg::ST_HO_RD: cmd.ho_init = 1'b1;
         ndd_pkg::ST_HO_SUB: begin
            cmd.idx_i = IW'(i_ff - 1'b1);
            cmd.ho_rd = 1'b1;
         end
         ndd_pkg::ST_HO_MUL: begin
            cmd.idx_i = IW'(i_ff - 1'b1);
            cmd.ho_mul = 1'b1;
         end
         ndd_pkg::ST_HO_WB: begin
            cmd.idx_i = IW'(i_ff - 1'b1);
            cmd.ho_wb = 1'b1;
         end
         ndd_pkg::ST_OUT: begin
            rsp_valid = 1'b1;
            cmd.clear_flags = rsp_ready;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ndd_pkg::ST_LOAD;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
      end
      n_ff <= n_in;
      i_ff <= i_in;
      j_ff <= j_in;
   end
endmodule
